// ===== rtl/core/dlb32_pkg.sv =====
package dlb32_pkg;

  // Longest third segment is MAX_NAME + 16 bytes
  localparam int MAX_NAME = 64;
  localparam logic [6:0] SEG0_SIZE = 7'd4;
  localparam logic [6:0] SEG1_SIZE = 7'd32;
  localparam logic [6:0] SEG2_SIZE = 7'(MAX_NAME + 16);

  // Address gaps between layout segments
  localparam logic [7:0] SEG0_GAP = 8'd20;
  localparam logic [7:0] SEG1_GAP = 8'd16;

  localparam logic [1:0] SEG_FIRST  = 2'd0;
  localparam logic [1:0] SEG_SECOND = 2'd1;
  localparam logic [1:0] SEG_TAIL   = 2'd2;

  localparam logic RES_DATA   = 1'b0;
  localparam logic RES_STATUS = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_CHAR  = 2'd1,
    ST_TOO_LONG  = 2'd2,
    ST_WRONG_SEG = 2'd3
  } status_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] value;
    logic [7:0] addr;
    status_t    status;
    logic [6:0] tail;
    logic       last;
  } result_t;

  // Results produced by one parser step
  typedef struct packed {
    result_t    res0;
    result_t    res1;
    logic [1:0] count;
  } step_out_t;

endpackage

// ===== rtl/core/dns_label_base32_unpacker_core.sv =====
// Base32 DNS name unpacker. Takes one raw name byte per transfer (length bytes
// and label characters, name_start on the first byte of a name) and gives out
// decoded bytes with their layout address, then one status transfer per name.
// One input byte is accepted every cycle while the output keeps up; a byte
// is held in the input register, is decoded in a single step, and its
// results are given out from a four-entry result queue. A byte that
// completes the last allowed tail byte yields two output transfers, the data
// byte and a too-long status, so the sustained rate is set by the output
// side at one result per cycle while out_stall is low.
module dns_label_base32_unpacker_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] text_byte,
  input  logic       name_start,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       result_kind,
  output logic [7:0] byte_value,
  output logic [7:0] byte_addr,
  output logic [1:0] status,
  output logic [6:0] tail_count,
  output logic       last
);
  import dlb32_pkg::*;

  // Input register
  logic       held;
  logic [7:0] byte_q;
  logic       start_q;
  logic       room;
  logic       step;
  logic       accept;
  step_out_t  step_out;
  result_t    out_data;

  assign step     = held && room;
  assign in_stall = held && !room;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (accept) begin
      held <= 1'b1;
    end else if (step) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byte_q  <= text_byte;
      start_q <= name_start;
    end
  end

  dlb32_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .text_byte  (byte_q),
    .name_start (start_q),
    .step_out   (step_out)
  );

  dlb32_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (step),
    .push_data (step_out),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Output fields
  assign result_kind = out_data.kind;
  assign byte_value  = out_data.value;
  assign byte_addr   = out_data.addr;
  assign status      = out_data.status;
  assign tail_count  = out_data.tail;
  assign last        = out_data.last;

endmodule

// ===== rtl/core/dlb32_parser.sv =====
module dlb32_parser (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic [7:0]           text_byte,
  input  logic                 name_start,
  output dlb32_pkg::step_out_t step_out
);
  import dlb32_pkg::*;

  // Parse state
  logic [7:0] label_left;
  logic [1:0] seg_index;
  logic [6:0] seg_count;
  logic [7:0] write_addr;
  logic [2:0] bit_pos;
  logic [7:0] partial_byte;
  logic       underscore_seen;
  logic       parsing;

  logic [7:0] label_left_next;
  logic [1:0] seg_index_next;
  logic [6:0] seg_count_next;
  logic [7:0] write_addr_next;
  logic [2:0] bit_pos_next;
  logic [7:0] partial_byte_next;
  logic       underscore_seen_next;
  logic       parsing_next;

  // State seen by this byte, after an optional name start
  logic [7:0] lbl_cur;
  logic [1:0] seg_cur;
  logic [6:0] cnt_cur;
  logic [7:0] addr_cur;
  logic [2:0] pos_cur;
  logic [7:0] part_cur;
  logic       us_cur;
  logic       run_cur;

  logic [4:0]  sym;
  logic        is_sym;
  logic        is_under;
  logic [11:0] acc;
  logic [3:0]  nb;
  logic [2:0]  nb_rem;
  logic [6:0]  cnt_inc;
  logic [6:0]  seg_size;
  logic [7:0]  seg_gap;
  result_t     data_res;

  // Finish: build a status result
  function automatic result_t make_status(status_t st, logic [1:0] seg, logic [6:0] cnt);
    result_t r;
    r        = '0;
    r.kind   = RES_STATUS;
    r.last   = 1'b1;
    r.status = st;
    if (st == ST_OK) begin
      if (seg == SEG_TAIL) begin
        r.tail = cnt;
      end else begin
        r.status = ST_WRONG_SEG;
      end
    end
    return r;
  endfunction

  // Symbol decode
  always_comb begin
    sym      = '0;
    is_sym   = 1'b0;
    is_under = 1'b0;
    if (text_byte >= 8'h41 && text_byte <= 8'h5A) begin
      sym    = 5'(text_byte - 8'h41);
      is_sym = 1'b1;
    end else if (text_byte >= 8'h61 && text_byte <= 8'h7A) begin
      sym    = 5'(text_byte - 8'h61);
      is_sym = 1'b1;
    end else if (text_byte >= 8'h30 && text_byte <= 8'h35) begin
      sym    = 5'(text_byte - 8'h30 + 8'd26);
      is_sym = 1'b1;
    end else if (text_byte == 8'h5F) begin
      is_under = 1'b1;
    end
  end

  // Step logic
  always_comb begin
    lbl_cur  = label_left;
    seg_cur  = seg_index;
    cnt_cur  = seg_count;
    addr_cur = write_addr;
    pos_cur  = bit_pos;
    part_cur = partial_byte;
    us_cur   = underscore_seen;
    run_cur  = parsing;
    if (name_start) begin
      lbl_cur  = '0;
      seg_cur  = '0;
      cnt_cur  = '0;
      addr_cur = '0;
      pos_cur  = '0;
      part_cur = '0;
      us_cur   = 1'b0;
      run_cur  = 1'b1;
    end

    acc     = {4'b0, part_cur} | ({7'b0, sym} << pos_cur);
    nb      = {1'b0, pos_cur} + 4'd5;
    nb_rem  = 3'(nb - 4'd8);
    cnt_inc = cnt_cur + 7'd1;

    case (seg_cur)
      SEG_FIRST:  begin seg_size = SEG0_SIZE; seg_gap = SEG0_GAP; end
      SEG_SECOND: begin seg_size = SEG1_SIZE; seg_gap = SEG1_GAP; end
      default:    begin seg_size = SEG2_SIZE; seg_gap = '0;       end
    endcase

    data_res       = '0;
    data_res.kind  = RES_DATA;
    data_res.value = acc[7:0];
    data_res.addr  = addr_cur;
    data_res.last  = 1'b1;

    label_left_next      = lbl_cur;
    seg_index_next       = seg_cur;
    seg_count_next       = cnt_cur;
    write_addr_next      = addr_cur;
    bit_pos_next         = pos_cur;
    partial_byte_next    = part_cur;
    underscore_seen_next = us_cur;
    parsing_next         = run_cur;
    step_out             = '0;

    if (run_cur) begin
      if (lbl_cur == '0) begin
        // Length byte; zero ends the name
        if (text_byte == '0) begin
          step_out.res0  = make_status(ST_OK, seg_cur, cnt_cur);
          step_out.count = 2'd1;
          parsing_next   = 1'b0;
        end else begin
          label_left_next = text_byte;
        end
      end else begin
        label_left_next = lbl_cur - 8'd1;
        if (is_under) begin
          // First underscore skipped, second ends the name
          if (!us_cur) begin
            underscore_seen_next = 1'b1;
          end else begin
            step_out.res0  = make_status(ST_OK, seg_cur, cnt_cur);
            step_out.count = 2'd1;
            parsing_next   = 1'b0;
          end
        end else if (!is_sym) begin
          step_out.res0  = make_status(ST_BAD_CHAR, seg_cur, cnt_cur);
          step_out.count = 2'd1;
          parsing_next   = 1'b0;
        end else if (nb < 4'd8) begin
          partial_byte_next = acc[7:0];
          bit_pos_next      = nb[2:0];
        end else begin
          // A byte completes
          partial_byte_next = {3'b0, sym >> (3'd5 - nb_rem)};
          bit_pos_next      = nb_rem;
          write_addr_next   = addr_cur + 8'd1;
          seg_count_next    = cnt_inc;
          step_out.res0     = data_res;
          step_out.count    = 2'd1;
          if (cnt_inc == seg_size) begin
            if (seg_cur >= SEG_TAIL) begin
              step_out.res0.last = 1'b0;
              step_out.res1      = make_status(ST_TOO_LONG, seg_cur, cnt_inc);
              step_out.count     = 2'd2;
              parsing_next       = 1'b0;
            end else begin
              write_addr_next = addr_cur + 8'd1 + seg_gap;
              seg_index_next  = seg_cur + 2'd1;
              seg_count_next  = '0;
            end
          end
        end
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      label_left      <= '0;
      seg_index       <= '0;
      seg_count       <= '0;
      write_addr      <= '0;
      bit_pos         <= '0;
      partial_byte    <= '0;
      underscore_seen <= 1'b0;
      parsing         <= 1'b0;
    end else if (step) begin
      label_left      <= label_left_next;
      seg_index       <= seg_index_next;
      seg_count       <= seg_count_next;
      write_addr      <= write_addr_next;
      bit_pos         <= bit_pos_next;
      partial_byte    <= partial_byte_next;
      underscore_seen <= underscore_seen_next;
      parsing         <= parsing_next;
    end
  end

endmodule

// ===== rtl/core/dlb32_queue.sv =====
module dlb32_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  dlb32_pkg::step_out_t push_data,
  output logic                 room,
  output logic                 out_valid,
  input  logic                 out_stall,
  output dlb32_pkg::result_t   out_data
);
  import dlb32_pkg::*;

  // Four-entry result queue: up to two writes, one read per cycle
  result_t    mem [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;
  logic [1:0] n_push;
  logic       pop;

  assign n_push    = push ? push_data.count : 2'd0;
  assign out_valid = (count != '0);
  assign out_data  = mem[rd_ptr];
  assign pop       = out_valid && !out_stall;
  // Room for a worst-case step, ignoring a pop in this cycle
  assign room      = (count <= 3'd2);

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      mem[wr_ptr] <= push_data.res0;
    end
    if (n_push == 2'd2) begin
      mem[wr_ptr + 2'd1] <= push_data.res1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + n_push;
      rd_ptr <= rd_ptr + {1'b0, pop};
      count  <= count + {1'b0, n_push} - {2'b0, pop};
    end
  end

endmodule
